### hdl/modbus_request_frame_builder_assert.svh
// Assertion macros for the request frame builder checker.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef MODBUS_REQUEST_FRAME_BUILDER_ASSERT_SVH
`define MODBUS_REQUEST_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MRFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MRFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mrfb_pkg.sv
// Shared types, constants and the CRC-16 byte step of the request frame builder.
// No dependencies; every module of the block imports this package.
`default_nettype none

package mrfb_pkg;

  // One command beat at the input.
  typedef struct packed {
    logic [15:0] register_address;
    logic [7:0]  device;
    logic [15:0] command_value;
  } cmd_t;

  // One frame byte beat at the output.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } res_t;

  // The six data bytes of a frame, in send order from the top.
  typedef struct packed {
    logic [7:0]  device;
    logic [7:0]  func_code;
    logic [15:0] address;
    logic [15:0] value;
  } frame_t;

  // Handshake between the decoder and the serializer.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_beat_t;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_REG = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_REG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURR_REG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_REG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_REG  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_FC     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RD_FC     = 3'd6;

  // Register reset values.
  localparam logic [15:0] RST_START_REG = 16'd0;
  localparam logic [15:0] RST_SPEED_REG = 16'd1;
  localparam logic [15:0] RST_CURR_REG  = 16'd2;
  localparam logic [15:0] RST_VOLT_REG  = 16'd3;
  localparam logic [15:0] RST_TEMP_REG  = 16'd4;
  localparam logic [7:0]  RST_WR_FC     = 8'd6;
  localparam logic [7:0]  RST_RD_FC     = 8'd3;

  // Value sent by every read request.
  localparam logic [15:0] READ_QUANTITY = 16'd1;

  // Frame byte positions.
  localparam int unsigned BYTE_IDX_W = 3;
  localparam logic [BYTE_IDX_W-1:0] CRC_LO_IDX = 3'd6;
  localparam logic [BYTE_IDX_W-1:0] CRC_HI_IDX = 3'd7;

  // CRC-16 Modbus.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Folds one byte into the running CRC, LSB first, reflected polynomial.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/modbus_request_frame_builder.sv
// Modbus RTU request frame builder: top level.
// Depends on mrfb_pkg, mrfb_decode and mrfb_serializer.
`default_nettype none

// A command is taken at a clock edge with start_i high and busy_o low. It is
// decoded in the next cycle; a command whose address matches a configured
// command address produces eight frame bytes on res_o, one per cycle with
// res_valid_o high, the first on the ports once the serializer has loaded the
// decoded frame, with the eighth flagged by last_byte. A command that matches
// nothing produces no bytes and frees the input the next cycle. The one-byte
// output channel sets the rate: frames go out back to back, since the next
// command is decoded and loaded while the current frame's last byte goes
// out. The receiver cannot stall, so each byte is valid for exactly one cycle
// and must be captured then. The user must write the configuration registers
// through cfg_we_i, cfg_idx_i and cfg_wdata_i only while the block is idle;
// the block itself does not enforce this.
module modbus_request_frame_builder
  import mrfb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire cmd_t                  cmd_i,
  output logic                       busy_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                       res_valid_o,
  output res_t                       res_o
);

  frame_beat_t frm;
  logic        take;

  // Command register and decode.
  mrfb_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .frm_o       (frm)
  );

  // Byte serializer and CRC.
  mrfb_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_i       (frm),
    .take_o      (take),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

### hdl/mrfb_decode.sv
// Command register, configuration registers and command decode.
// Depends on mrfb_pkg; feeds mrfb_serializer.
`default_nettype none

module mrfb_decode
  import mrfb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire cmd_t                  cmd_i,
  output logic                       busy_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  take_i,
  output frame_beat_t                frm_o
);

  logic [15:0] start_reg_q, speed_reg_q, curr_reg_q, volt_reg_q, temp_reg_q;
  logic [7:0]  wr_fc_q, rd_fc_q;

  logic        vld_q, vld_d;
  cmd_t        cmd_q;
  logic        accept;
  logic        drain;
  logic        match;
  logic [7:0]  fc;
  logic [15:0] value;
  logic [15:0] value_x10;

  // Configuration register writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_reg_q <= RST_START_REG;
      speed_reg_q <= RST_SPEED_REG;
      curr_reg_q  <= RST_CURR_REG;
      volt_reg_q  <= RST_VOLT_REG;
      temp_reg_q  <= RST_TEMP_REG;
      wr_fc_q     <= RST_WR_FC;
      rd_fc_q     <= RST_RD_FC;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_REG: start_reg_q <= cfg_wdata_i;
        CFG_SPEED_REG: speed_reg_q <= cfg_wdata_i;
        CFG_CURR_REG:  curr_reg_q  <= cfg_wdata_i;
        CFG_VOLT_REG:  volt_reg_q  <= cfg_wdata_i;
        CFG_TEMP_REG:  temp_reg_q  <= cfg_wdata_i;
        CFG_WR_FC:     wr_fc_q     <= cfg_wdata_i[7:0];
        CFG_RD_FC:     rd_fc_q     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Speed is scaled by ten as 8x + 2x, wrapping at 16 bits.
  assign value_x10 = {cmd_q.command_value[12:0], 3'b000} + {cmd_q.command_value[14:0], 1'b0};

  // First matching command address wins, in start, speed, read order.
  always_comb begin
    match = 1'b1;
    fc    = wr_fc_q;
    value = cmd_q.command_value;
    if (cmd_q.register_address == start_reg_q) begin
      fc    = wr_fc_q;
      value = cmd_q.command_value;
    end else if (cmd_q.register_address == speed_reg_q) begin
      fc    = wr_fc_q;
      value = value_x10;
    end else if (cmd_q.register_address == curr_reg_q ||
                 cmd_q.register_address == volt_reg_q ||
                 cmd_q.register_address == temp_reg_q) begin
      fc    = rd_fc_q;
      value = READ_QUANTITY;
    end else begin
      match = 1'b0;
    end
  end

  // A held command leaves when the serializer takes it or when it matches nothing.
  assign drain  = vld_q && (!match || take_i);
  assign busy_o = vld_q && !drain;
  assign accept = start_i && !busy_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (drain) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  assign frm_o.valid           = vld_q && match;
  assign frm_o.frame.device    = cmd_q.device;
  assign frm_o.frame.func_code = fc;
  assign frm_o.frame.address   = cmd_q.register_address;
  assign frm_o.frame.value     = value;

endmodule

`default_nettype wire

### hdl/mrfb_serializer.sv
// Frame byte serializer with a byte-wide running CRC-16.
// Depends on mrfb_pkg; fed by mrfb_decode.
`default_nettype none

module mrfb_serializer
  import mrfb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire frame_beat_t frm_i,
  output logic             take_o,
  output logic             res_valid_o,
  output res_t             res_o
);

  logic                  vld_q, vld_d;
  logic [BYTE_IDX_W-1:0] cnt_q, cnt_d;
  logic [47:0]           data_q, data_d;
  logic [15:0]           crc_q, crc_d;
  logic                  load;

  // A new frame can load while the last byte of the current one goes out.
  assign take_o = !vld_q || (cnt_q == CRC_HI_IDX);
  assign load   = frm_i.valid && take_o;

  // Data bytes shift out from the top; the CRC folds in each data byte as it is sent.
  always_comb begin
    vld_d  = vld_q;
    cnt_d  = cnt_q;
    data_d = data_q;
    crc_d  = crc_q;
    if (load) begin
      vld_d  = 1'b1;
      cnt_d  = '0;
      data_d = frm_i.frame;
      crc_d  = CRC_INIT;
    end else if (vld_q) begin
      cnt_d  = cnt_q + 1'b1;
      data_d = {data_q[39:0], 8'h00};
      if (cnt_q < CRC_LO_IDX) begin
        crc_d = crc_byte(crc_q, data_q[47:40]);
      end
      if (cnt_q == CRC_HI_IDX) begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    crc_q  <= crc_d;
  end

  // Output byte select: data bytes, then CRC low, then CRC high.
  always_comb begin
    case (cnt_q)
      CRC_LO_IDX: res_o.frame_byte = crc_q[7:0];
      CRC_HI_IDX: res_o.frame_byte = crc_q[15:8];
      default:    res_o.frame_byte = data_q[47:40];
    endcase
  end

  assign res_o.last_byte = vld_q && (cnt_q == CRC_HI_IDX);
  assign res_valid_o     = vld_q;

endmodule

`default_nettype wire

### hdl/mrfb_checker.sv
// Port-level checks of the request frame builder, bound to the top level.
// Depends on mrfb_pkg and modbus_request_frame_builder_assert.svh.
`default_nettype none

`include "modbus_request_frame_builder_assert.svh"

module mrfb_checker
  import mrfb_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic res_valid_o,
  input wire res_t res_o
);

  // A frame is eight unbroken beats ending with the last-byte flag.
  `MRFB_ASSERT_NOW(a_last_after_eight, res_valid_o && res_o.last_byte, $past(res_valid_o, 7) && !$past(res_o.last_byte, 1), "frame shorter than eight bytes")
  `MRFB_ASSERT_NEXT(a_frame_unbroken, res_valid_o && !res_o.last_byte, res_valid_o, "frame broken before its last byte")
  `MRFB_ASSERT_NOW(a_stop_after_last, $fell(res_valid_o), $past(res_o.last_byte), "byte strobe stopped without last byte")

  // Busy only rises after a command was taken.
  `MRFB_ASSERT_NOW(a_busy_after_cmd, $rose(busy_o), $past(start_i), "busy rose without a command")

endmodule

bind modbus_request_frame_builder mrfb_checker u_mrfb_checker (.*);

`default_nettype wire
